### src/bcp_pkg.sv
// Package for the brightness/contrast pixel block.
// Holds the fixed-point widths, the per-item coefficient bundle and the reciprocal constants.
// No dependencies.
`timescale 1ns / 1ps
package bcp_pkg;
	localparam int FRAC_BITS = 12;
	localparam int COL_W = 16;
	localparam int ALPHA_W = 13;
	localparam int PCT_W = 8;
	localparam int NUM_LANES = 3;
	// Reciprocal scale: quotient estimate is (m * R) >> RCP_SHIFT.
	localparam int RCP_SHIFT = 30;
	localparam int DEN_W = 14;
	localparam int M_W = 30;
	localparam logic [DEN_W-1:0] DEN_NEG = DEN_W'(10000);
	localparam logic [RCP_SHIFT-1:0] RCP_NEG = RCP_SHIFT'((64'd1 << RCP_SHIFT) / 10000);
	localparam logic [ALPHA_W-1:0] W_ONE = ALPHA_W'(1 << FRAC_BITS);
	localparam int STAGES = 6;

	// Per-item coefficients: numerator n = a*c + b*w, result = round(n / den).
	typedef struct packed {
		logic signed [14:0] a;
		logic signed [15:0] b;
		logic [ALPHA_W-1:0] w;
		logic [DEN_W-1:0] den;
		logic [RCP_SHIFT-1:0] rcp;
		logic inf;
		logic zero;
	} coef_t;
endpackage

### src/bcp_coef.sv
// Coefficient stage: forms gain, offset, divisor and reciprocal for one item.
// Depends on bcp_pkg; result is registered as stage 1.
`timescale 1ns / 1ps
module bcp_coef import bcp_pkg::*; (
	input logic clk,
	input logic en,
	input logic mode,
	input logic [ALPHA_W-1:0] alpha,
	input logic signed [PCT_W-1:0] br,
	input logic signed [PCT_W-1:0] ct,
	output coef_t coef_s1
);
	logic [RCP_SHIFT-1:0] rtab [0:127];
	coef_t coef_d;
	logic signed [8:0] gain;
	logic signed [15:0] gbr;

	// Reciprocal table of 2^30 / (2*(100-ct)) for positive contrast below 100.
	for (genvar k = 0; k < 128; k++) begin : g_rcp
		localparam int DV = (k >= 1 && k <= 99) ? 2 * (100 - k) : 1;
		localparam logic [RCP_SHIFT-1:0] RV = (k >= 1 && k <= 99) ?
			RCP_SHIFT'((64'd1 << RCP_SHIFT) / DV) : '0;
		assign rtab[k] = RV;
	end

	// Select the contrast branch and build the coefficients.
	always_comb begin
		gain = 9'sd100 + 9'(ct);
		gbr = 16'(gain) * 16'(br);
		coef_d.w = mode ? alpha : W_ONE;
		coef_d.zero = mode && (alpha == '0);
		coef_d.inf = 1'b0;
		coef_d.a = 15'sd200;
		coef_d.b = 16'sd2 * 16'(br) - 16'(ct);
		coef_d.den = DEN_NEG;
		coef_d.rcp = RCP_NEG;
		if (ct >= 8'sd100) begin
			coef_d.inf = 1'b1;
			coef_d.b = 16'sd2 * 16'(br) - 16'sd100;
		end else if (ct > 8'sd0) begin
			coef_d.den = DEN_W'(2 * (100 - 32'(ct)));
			coef_d.rcp = rtab[ct[6:0]];
		end else begin
			coef_d.a = 15'(gain) * 15'sd100;
			coef_d.b = gbr - 16'sd50 * 16'(ct);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s1 <= coef_d;
		end
	end
endmodule

### src/bcp_lane.sv
// One color lane: numerator, reciprocal divide with correction, rounding and saturation.
// Depends on bcp_pkg; five registered stages after the coefficient stage.
`timescale 1ns / 1ps
module bcp_lane import bcp_pkg::*; (
	input logic clk,
	input logic en,
	input coef_t coef_s1,
	input logic signed [COL_W-1:0] col_s1,
	output logic signed [COL_W-1:0] res_s6
);
	typedef struct packed {
		logic inf;
		logic zero;
		logic neg;
		logic pos;
		logic [DEN_W-1:0] den;
	} lflag_t;

	logic signed [30:0] pa_s2;
	logic signed [29:0] pb_s2;
	coef_t coef_s2;
	lflag_t fl_s3, fl_s4, fl_s5;
	logic [M_W-1:0] m_s3, m_s4, m_s5;
	logic [RCP_SHIFT-1:0] rcp_s3;
	logic [M_W+RCP_SHIFT-1:0] p_s4;
	logic [M_W+DEN_W-1:0] t_s5;
	logic [M_W-1:0] qe_s5;
	logic signed [31:0] n_d;
	logic [31:0] abs_d;
	logic [M_W-1:0] qe_d;
	logic [M_W:0] r_d;
	logic [M_W-1:0] q_d;
	logic signed [COL_W-1:0] res_d;

	// Stage 2: the two products of the numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2 <= 31'(coef_s1.a) * 31'(col_s1);
			pb_s2 <= 30'(coef_s1.b) * $signed({17'd0, coef_s1.w});
			coef_s2 <= coef_s1;
		end
	end

	// Stage 3: sum, magnitude plus half divisor for rounding.
	always_comb begin
		n_d = 32'(pa_s2) + 32'(pb_s2);
		abs_d = n_d[31] ? 32'(-n_d) : 32'(n_d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3 <= M_W'(abs_d) + M_W'(coef_s2.den >> 1);
			rcp_s3 <= coef_s2.rcp;
			fl_s3 <= '{inf: coef_s2.inf, zero: coef_s2.zero, neg: n_d[31],
				pos: (n_d > 32'sd0), den: coef_s2.den};
		end
	end

	// Stage 4: quotient estimate by reciprocal multiply.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s4 <= (M_W+RCP_SHIFT)'(m_s3) * (M_W+RCP_SHIFT)'(rcp_s3);
			m_s4 <= m_s3;
			fl_s4 <= fl_s3;
		end
	end

	// Stage 5: back-multiply the estimate for the remainder check.
	assign qe_d = p_s4[M_W+RCP_SHIFT-1:RCP_SHIFT];

	always_ff @(posedge clk) begin
		if (en) begin
			qe_s5 <= qe_d;
			t_s5 <= (M_W+DEN_W)'(qe_d) * (M_W+DEN_W)'(fl_s4.den);
			m_s5 <= m_s4;
			fl_s5 <= fl_s4;
		end
	end

	// Stage 6: the estimate is at most one short; fix it, apply sign and saturate.
	always_comb begin
		r_d = (M_W+1)'(m_s5) - (M_W+1)'(t_s5);
		q_d = qe_s5 + M_W'(r_d >= (M_W+1)'(fl_s5.den));
		if (fl_s5.zero) begin
			res_d = '0;
		end else if (fl_s5.inf) begin
			res_d = fl_s5.pos ? 16'sh7fff : (fl_s5.neg ? 16'sh8000 : 16'sh0000);
		end else if (fl_s5.neg) begin
			res_d = (q_d > M_W'(32768)) ? 16'sh8000 : 16'(-q_d);
		end else begin
			res_d = (q_d > M_W'(32767)) ? 16'sh7fff : 16'(q_d);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= res_d;
		end
	end
endmodule

### src/brightness_contrast_pixel.sv
// Top level of the brightness/contrast pixel block: coefficient stage, three color lanes
// and the output stage that merges them. Depends on bcp_pkg, bcp_coef and bcp_lane.
//
// channel  direction  signals
// in       input      in_valid/in_ready, in_red, in_green, in_blue, in_alpha,
//                     brightness_pct, contrast_pct
// out      output     out_valid/out_ready, out_red, out_green, out_blue, out_alpha
// cfg      input      cfg_valid/cfg_ready, cfg_data (premultiplied mode)
//
// One item per cycle is accepted while the output stage is empty or being taken.
// The depth is set by the multiplies in each lane: the numerator and the reciprocal divide.
// A stalled output holds the whole pipeline; in_ready is high unless the output stalls.
// Reset clears the stage valid bits and the mode register; cfg_ready is always high.
`timescale 1ns / 1ps
module brightness_contrast_pixel import bcp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [COL_W-1:0] in_red,
	input logic signed [COL_W-1:0] in_green,
	input logic signed [COL_W-1:0] in_blue,
	input logic [ALPHA_W-1:0] in_alpha,
	input logic signed [PCT_W-1:0] brightness_pct,
	input logic signed [PCT_W-1:0] contrast_pct,
	output logic out_valid,
	input logic out_ready,
	output logic signed [COL_W-1:0] out_red,
	output logic signed [COL_W-1:0] out_green,
	output logic signed [COL_W-1:0] out_blue,
	output logic [ALPHA_W-1:0] out_alpha,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);
	logic mode_q;
	logic [STAGES-1:0] vld_q;
	logic [ALPHA_W-1:0] alpha_q [0:STAGES-1];
	logic signed [COL_W-1:0] col_s1 [0:NUM_LANES-1];
	logic signed [COL_W-1:0] res_s6 [0:NUM_LANES-1];
	coef_t coef_s1;
	logic en;

	// The pipeline moves whenever the output stage is empty or being taken.
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	// Alpha and raw colors travel alongside the lanes.
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_q[0] <= in_alpha;
			for (int i = 1; i < STAGES; i++) begin
				alpha_q[i] <= alpha_q[i-1];
			end
			col_s1[0] <= in_red;
			col_s1[1] <= in_green;
			col_s1[2] <= in_blue;
		end
	end

	bcp_coef u_coef (
		.clk(clk),
		.en(en),
		.mode(mode_q),
		.alpha(in_alpha),
		.br(brightness_pct),
		.ct(contrast_pct),
		.coef_s1(coef_s1)
	);

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		bcp_lane u_lane (
			.clk(clk),
			.en(en),
			.coef_s1(coef_s1),
			.col_s1(col_s1[l]),
			.res_s6(res_s6[l])
		);
	end

	// Output stage: the lane results and alpha form one item.
	assign out_valid = vld_q[STAGES-1];
	assign out_red = res_s6[0];
	assign out_green = res_s6[1];
	assign out_blue = res_s6[2];
	assign out_alpha = alpha_q[STAGES-1];
endmodule

### src/bcp_checker.sv
// Port-level checker for brightness_contrast_pixel, bound to the top level.
// Depends on bcp_pkg.
`timescale 1ns / 1ps
module bcp_checker import bcp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_ready,
	input logic signed [COL_W-1:0] out_red,
	input logic [ALPHA_W-1:0] out_alpha
);
	// The input side is never blocked while the output is empty or being taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output stage");

	// Configuration writes are always taken.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("cfg_ready low");

	// A stalled item keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_alpha))
		else $error("stalled output item changed");

	// An item leaves only when taken.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("output item dropped");
endmodule

bind brightness_contrast_pixel bcp_checker u_bcp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.cfg_ready(cfg_ready),
	.out_red(out_red),
	.out_alpha(out_alpha)
);

### bench/tb.sv
// Self-checking bench for brightness_contrast_pixel: random and directed pixels,
// both alpha modes, handshake stalls on both sides. Depends on bcp_pkg and the block RTL.
`timescale 1ns / 1ps
module tb;
	import bcp_pkg::*;

	typedef struct packed {
		logic signed [COL_W-1:0] red;
		logic signed [COL_W-1:0] green;
		logic signed [COL_W-1:0] blue;
		logic [ALPHA_W-1:0] alpha;
		logic signed [PCT_W-1:0] bright;
		logic signed [PCT_W-1:0] contr;
	} pixel_t;

	typedef struct packed {
		logic signed [COL_W-1:0] red;
		logic signed [COL_W-1:0] green;
		logic signed [COL_W-1:0] blue;
		logic [ALPHA_W-1:0] alpha;
	} adj_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [COL_W-1:0] in_red = '0, in_green = '0, in_blue = '0;
	logic [ALPHA_W-1:0] in_alpha = '0;
	logic signed [PCT_W-1:0] brightness_pct = '0, contrast_pct = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [COL_W-1:0] out_red, out_green, out_blue;
	logic [ALPHA_W-1:0] out_alpha;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	pixel_t pending_pixels[$];
	adj_t expected_pixels[$];
	logic premul_mode = 1'b0;
	logic calm = 1'b0;
	logic in_taken = 1'b0;
	int errors = 0;
	int in_idle = 0;
	int out_idle = 0;

	brightness_contrast_pixel i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
		.brightness_pct(brightness_pct), .contrast_pct(contrast_pct),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.out_alpha(out_alpha),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Rounded division, ties away from zero; den is positive.
	function automatic longint round_div(longint num, longint den);
		if (num < 0) begin
			return -((-num + den / 2) / den);
		end
		return (num + den / 2) / den;
	endfunction

	function automatic logic signed [COL_W-1:0] clip_color(longint v);
		if (v > 32767) begin
			return 16'sd32767;
		end
		if (v < -32768) begin
			return -16'sd32768;
		end
		return COL_W'(v);
	endfunction

	// One color channel: exact rational gain/offset, rounded once and saturated.
	function automatic logic signed [COL_W-1:0] adjust_color(longint c, longint w,
			longint br, longint ct);
		longint num;
		longint g;
		if (ct >= 100) begin
			num = 200 * c + (2 * br - 100) * w;
			if (num > 0) begin
				return 16'sd32767;
			end
			if (num < 0) begin
				return -16'sd32768;
			end
			return '0;
		end
		if (ct > 0) begin
			num = 200 * c + (2 * br - ct) * w;
			return clip_color(round_div(num, 2 * (100 - ct)));
		end
		g = 100 + ct;
		num = g * 100 * c + (g * br - 50 * ct) * w;
		return clip_color(round_div(num, 10000));
	endfunction

	function automatic adj_t predict_pixel(pixel_t p, logic premul);
		adj_t r;
		longint w;
		w = premul ? longint'(p.alpha) : longint'(1 << FRAC_BITS);
		r.alpha = p.alpha;
		if (premul && p.alpha == 0) begin
			r.red = '0;
			r.green = '0;
			r.blue = '0;
		end else begin
			r.red = adjust_color(p.red, w, p.bright, p.contr);
			r.green = adjust_color(p.green, w, p.bright, p.contr);
			r.blue = adjust_color(p.blue, w, p.bright, p.contr);
		end
		return r;
	endfunction

	// Record at the rising edge whether the input item was taken.
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
	end

	// Input driver: fed from the pending queue, predicts on acceptance.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				expected_pixels.push_back(predict_pixel({in_red, in_green, in_blue,
					in_alpha, brightness_pct, contrast_pct}, premul_mode));
			end
			if (!in_valid || in_taken) begin
				if (in_idle > 0) begin
					in_idle--;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					pixel_t p;
					p = pending_pixels.pop_front();
					{in_red, in_green, in_blue, in_alpha, brightness_pct, contrast_pct} <= p;
					in_valid <= 1'b1;
					if (!calm && $urandom_range(0, 7) == 0) begin
						in_idle = $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
			// Output stalls come in bursts too.
			if (out_idle > 0) begin
				out_idle--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0) begin
					out_idle = $urandom_range(1, 6);
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %h", $time,
					out_red, out_green, out_blue, out_alpha);
				errors++;
			end else begin
				adj_t e;
				e = expected_pixels.pop_front();
				if (e != {out_red, out_green, out_blue, out_alpha}) begin
					$display("%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d",
						$time, e.red, e.green, e.blue, e.alpha);
					$display("%0t:          actual   r=%0d g=%0d b=%0d a=%0d",
						$time, out_red, out_green, out_blue, out_alpha);
					errors++;
				end
			end
		end
	end

	function automatic pixel_t random_pixel();
		pixel_t p;
		p.red = $urandom;
		p.green = $urandom;
		p.blue = $urandom;
		case ($urandom_range(0, 5))
			0: p.alpha = 0;
			1: p.alpha = 4096;
			2: p.alpha = $urandom;
			default: p.alpha = $urandom_range(0, 4096);
		endcase
		if ($urandom_range(0, 9) == 0) begin
			p.bright = $urandom;
			p.contr = $urandom;
		end else begin
			p.bright = $urandom_range(0, 200) - 100;
			p.contr = $urandom_range(0, 200) - 100;
		end
		if ($urandom_range(0, 3) == 0) begin
			p.red = $urandom_range(0, 4096);
			p.green = $urandom_range(0, 4096);
			p.blue = $urandom_range(0, 4096);
		end
		return p;
	endfunction

	task automatic wait_drained();
		while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic write_mode(logic m);
		@(negedge clk);
		cfg_data <= m;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		premul_mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_directed();
		pending_pixels.push_back({16'sh7fff, -16'sh8000, 16'sh0000, 13'd4096, 8'sd0, 8'sd0});
		pending_pixels.push_back({16'sh7fff, -16'sh8000, 16'sh1000, 13'd4096, 8'sd100, 8'sd100});
		pending_pixels.push_back({16'sh0800, 16'sh0000, -16'sh0001, 13'd4096, 8'sd50, 8'sd100});
		pending_pixels.push_back({16'sh0800, 16'sh0400, 16'sh0c00, 13'd2048, -8'sd100, -8'sd100});
		pending_pixels.push_back({16'sh0800, 16'sh0400, 16'sh0c00, 13'd0, 8'sd20, 8'sd40});
		pending_pixels.push_back({16'sh7fff, 16'sh7fff, 16'sh7fff, 13'h1fff, 8'sh7f, 8'sh7f});
		pending_pixels.push_back({-16'sh8000, 16'sh0001, 16'sh0fff, 13'h1fff, -8'sh80, -8'sh80});
		pending_pixels.push_back({16'sh1000, 16'sh0000, 16'sh0800, 13'd4096, -8'sd100, 8'sd99});
		pending_pixels.push_back({16'sh1000, 16'sh0000, 16'sh0800, 13'd1, 8'sd100, -8'sd50});
		pending_pixels.push_back({16'sh0555, 16'shaaaa, 16'sh5555, 13'h0aaa, 8'sh55, -8'sh2b});
		pending_pixels.push_back({16'shaaaa, 16'sh5555, 16'shaaaa, 13'h1555, -8'sh56, 8'sh2a});
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			write_mode(phase[0]);
			add_directed();
			for (int k = 0; k < 160; k++) begin
				pending_pixels.push_back(random_pixel());
			end
			if (phase == 3) begin
				calm = 1'b1;
			end
			wait_drained();
		end
		if (errors == 0) begin
			$display("** brightness_contrast_pixel: PASSED **");
		end else begin
			$display("** brightness_contrast_pixel: FAILED **");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("** brightness_contrast_pixel: FAILED **");
		$finish;
	end
endmodule
